// File: rtl/core/sra_pkg.sv
// Shared types, codes and defaults of the segment reorder and cumulative ack block.
`timescale 1ns / 1ps

package sra_pkg;

  // Default number of hold table entries.
  localparam int HOLD_DEPTH_DEF = 32;

  // Result kinds.
  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FINACK  = 2'd2;

  // Input actions.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_FIN  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] seg_start;
    logic [15:0] seg_bytes;
    logic [7:0]  buffer_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_start;
    logic [15:0] out_bytes;
    logic [7:0]  out_tag;
    logic [31:0] ack_point;
    logic        last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;     // capture the input word, clear the drain list
    logic seg_key;    // compare key takes the segment start
    logic first_adv;  // point advances by the segment length
    logic ins;        // hold the segment if no duplicate and room
    logic take;       // take the lowest matching entry into the drain list
    logic adv;        // point advances by the length just read
    logic prune;      // free entries the point has passed
    logic rd_order;   // read the entry at the current drain list place
    logic ld_first;   // output takes the segment itself
    logic ld_drain;   // output takes the entry just read
    logic ld_last;    // output takes the closing ack or finack
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fin;
    logic seg_gt;
    logic seg_eq;
    logic any_eq;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/sra_stream_if.sv
// Valid/ready stream interface that carries one word of type T.
`timescale 1ns / 1ps

interface sra_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sra_dpath.sv
// Datapath: ack point, hold table lanes and memory, drain list and output register.
`timescale 1ns / 1ps

module sra_dpath
  import sra_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  in_word_t              seg_r;
  logic [31:0]           exp_r;
  logic [31:0]           exp_nxt;
  logic [31:0]           key_r;
  logic [HOLD_DEPTH-1:0] valid_r;
  logic [HOLD_DEPTH-1:0] valid_nxt;
  logic [31:0]           lane_start_r [HOLD_DEPTH];
  logic [HOLD_DEPTH-1:0] eq_r;
  logic [HOLD_DEPTH-1:0] lt_r;
  logic [HOLD_DEPTH-1:0] eq_nxt;
  logic [HOLD_DEPTH-1:0] lt_nxt;

  logic [31:0]           mem_start [HOLD_DEPTH];
  logic [15:0]           mem_len   [HOLD_DEPTH];
  logic [7:0]            mem_tag   [HOLD_DEPTH];
  logic [31:0]           rd_start_r;
  logic [15:0]           rd_len_r;
  logic [7:0]            rd_tag_r;

  logic [IW-1:0]         order_r [HOLD_DEPTH];
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         k_r;

  out_word_t             out_r;
  logic                  out_valid_r;

  logic [IW-1:0]         match_idx;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         ord_idx;
  logic [IW-1:0]         rd_addr;
  logic                  rd_en;
  logic                  do_ins;

  function automatic logic [IW-1:0] lowest_set(input logic [HOLD_DEPTH-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = HOLD_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  // Every lane compares its start against the key and against the point.
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      eq_nxt[i] = valid_r[i] && (lane_start_r[i] == key_r);
      lt_nxt[i] = valid_r[i] && (lane_start_r[i] < exp_r);
    end
  end

  assign match_idx = lowest_set(eq_r);
  assign free_idx  = lowest_set(~valid_r);
  assign ord_idx   = order_r[k_r[IW-1:0]];
  assign rd_addr   = cmd.take ? match_idx : ord_idx;
  assign rd_en     = cmd.take || cmd.rd_order;
  assign do_ins    = cmd.ins && !(|eq_r) && !(&valid_r);

  always_comb begin
    exp_nxt = exp_r;
    if (cmd.first_adv) begin
      exp_nxt = exp_r + {16'b0, seg_r.seg_bytes};
    end else if (cmd.adv) begin
      exp_nxt = exp_r + {16'b0, rd_len_r};
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (do_ins) valid_nxt[free_idx] = 1'b1;
    if (cmd.take) valid_nxt[match_idx] = 1'b0;
    if (cmd.prune) valid_nxt = valid_r & ~lt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      exp_r   <= exp_nxt;
      valid_r <= valid_nxt;
      if (cmd.cap_in) begin
        cnt_r <= '0;
        k_r   <= '0;
      end else begin
        if (cmd.take) cnt_r <= cnt_r + CW'(1);
        if (cmd.ld_drain) k_r <= k_r + CW'(1);
      end
      if (cmd.ld_first || cmd.ld_drain || cmd.ld_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eq_r <= eq_nxt;
    lt_r <= lt_nxt;
    if (cmd.cap_in) seg_r <= in_word;
    if (cmd.seg_key) begin
      key_r <= seg_r.seg_start;
    end else if (cmd.first_adv || cmd.adv) begin
      key_r <= exp_nxt;
    end
    if (do_ins) begin
      lane_start_r[free_idx] <= seg_r.seg_start;
      mem_start[free_idx]    <= seg_r.seg_start;
      mem_len[free_idx]      <= seg_r.seg_bytes;
      mem_tag[free_idx]      <= seg_r.buffer_tag;
    end
    if (rd_en) begin
      rd_start_r <= mem_start[rd_addr];
      rd_len_r   <= mem_len[rd_addr];
      rd_tag_r   <= mem_tag[rd_addr];
    end
    if (cmd.take) order_r[cnt_r[IW-1:0]] <= match_idx;
    if (cmd.ld_first) begin
      out_r <= '{kind: KIND_DELIVER, out_start: seg_r.seg_start, out_bytes: seg_r.seg_bytes,
                 out_tag: seg_r.buffer_tag, ack_point: exp_r, last: 1'b0};
    end else if (cmd.ld_drain) begin
      out_r <= '{kind: KIND_DELIVER, out_start: rd_start_r, out_bytes: rd_len_r,
                 out_tag: rd_tag_r, ack_point: exp_r, last: 1'b0};
    end else if (cmd.ld_last) begin
      out_r <= '{kind: (seg_r.action == ACT_FIN) ? KIND_FINACK : KIND_ACK,
                 out_start: 32'd0, out_bytes: 16'd0, out_tag: 8'd0,
                 ack_point: exp_r, last: 1'b1};
    end
  end

  assign sts.is_fin   = (seg_r.action == ACT_FIN);
  assign sts.seg_gt   = (seg_r.seg_start > exp_r);
  assign sts.seg_eq   = (seg_r.seg_start == exp_r);
  assign sts.any_eq   = |eq_r;
  assign sts.more     = (k_r < cnt_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/sra_ctrl.sv
// Controller: sequences classify, hold, drain, prune and result emission per word.
`timescale 1ns / 1ps

module sra_ctrl
  import sra_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_HCMP  = 4'd2;
  localparam logic [3:0] S_HINS  = 4'd3;
  localparam logic [3:0] S_DCMP  = 4'd4;
  localparam logic [3:0] S_DFIND = 4'd5;
  localparam logic [3:0] S_DADD  = 4'd6;
  localparam logic [3:0] S_EFRST = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_EDRN  = 4'd9;
  localparam logic [3:0] S_ELAST = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       first_r;
  logic       first_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    first_nxt = first_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_CLASS;
        end
      end
      S_CLASS: begin
        first_nxt = 1'b0;
        if (sts.is_fin) begin
          state_nxt = S_ELAST;
        end else if (sts.seg_gt) begin
          cmd.seg_key = 1'b1;
          state_nxt   = S_HCMP;
        end else if (sts.seg_eq) begin
          cmd.first_adv = 1'b1;
          first_nxt     = 1'b1;
          state_nxt     = S_DCMP;
        end else begin
          state_nxt = S_ELAST;
        end
      end
      S_HCMP: state_nxt = S_HINS;
      S_HINS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_ELAST;
      end
      S_DCMP: state_nxt = S_DFIND;
      S_DFIND: begin
        if (sts.any_eq) begin
          cmd.take  = 1'b1;
          state_nxt = S_DADD;
        end else begin
          cmd.prune = 1'b1;
          state_nxt = S_EFRST;
        end
      end
      S_DADD: begin
        cmd.adv   = 1'b1;
        state_nxt = S_DCMP;
      end
      S_EFRST: begin
        if (!first_r) begin
          state_nxt = S_ERD;
        end else if (sts.out_free) begin
          cmd.ld_first = 1'b1;
          state_nxt    = S_ERD;
        end
      end
      S_ERD: begin
        if (sts.more) begin
          cmd.rd_order = 1'b1;
          state_nxt    = S_EDRN;
        end else begin
          state_nxt = S_ELAST;
        end
      end
      S_EDRN: begin
        if (sts.out_free) begin
          cmd.ld_drain = 1'b1;
          state_nxt    = S_ERD;
        end
      end
      S_ELAST: begin
        if (sts.out_free) begin
          cmd.ld_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  a_accept_classifies: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CLASS))
    else $error("accepted word did not move to classification");

  a_take_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> sts.any_eq)
    else $error("drain take issued without a matching entry");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_first || cmd.ld_drain || cmd.ld_last) |-> sts.out_free)
    else $error("output register overwritten while still held");

  a_last_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_last |=> (state_r == S_IDLE))
    else $error("closing result did not return the controller to idle");

endmodule

// File: rtl/core/segment_reorder_cumulative_ack_top.sv
// Top level of the segment reorder buffer with cumulative acknowledgement.
`timescale 1ns / 1ps

// Usage: in_chan carries one segment descriptor word (action, seg_start, seg_bytes,
// buffer_tag); out_chan carries result words (kind, out_start, out_bytes, out_tag,
// ack_point, last). Both use valid/ready; a word moves when both are high.
// A data word below the ack point yields only an ack. A word above the point is
// held in the lowest free table entry unless its start is already held or the
// table is full. A word at the point is delivered, held entries that continue the
// point are then delivered in order, passed entries are freed, and an ack closes.
// A finish word yields one finack. Every word in a burst carries the final point,
// and the closing word has last set.
// Lookups use the registered lane compare vectors; the entry memory has one read port.
// One word is worked at a time; the next is accepted once the closing result
// sits in the output register, even while that result waits to be taken.
// A stalled receiver holds the output register and halts emission in place.
// Reset (rst_n low, synchronous) zeroes the ack point and empties the table.

module segment_reorder_cumulative_ack_top
  import sra_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  sra_stream_if.sink   in_chan,
  sra_stream_if.source out_chan
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      in_ready;
  out_word_t out_word;
  logic      out_valid;

  // The controller alone decides when a word is taken.
  assign in_chan.ready = in_ready;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sra_dpath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_chan.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_chan.ready)
  );

  // The output register drives the result channel directly.
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_word;

endmodule

// File: verif/segment_reorder_cumulative_ack_top_test.sv
// Self-checking testbench for the segment reorder buffer with cumulative acknowledgement.
`timescale 1ns / 1ps

module segment_reorder_cumulative_ack_top_test
  import sra_pkg::*;
;

  localparam int HOLD_SLOTS      = HOLD_DEPTH_DEF;
  // Stride and length of the segments that fill the hold table.
  localparam int TABLE_STRIDE    = 1000;
  // About 120 window segments; with the noise and the directed words the run sends
  // about 200 descriptors.
  localparam int RANDOM_SEGMENTS = 120;
  // Leave room beyond the longest in-order burst at the end.
  localparam int TAIL_CYCLES     = 300;
  // No word moving on either side for this long means the block is stuck.
  localparam int WATCHDOG_LIMIT  = 3000;

  logic clk;
  logic rst_n;

  sra_stream_if #(.T(in_word_t))  in_if ();
  sra_stream_if #(.T(out_word_t)) out_if ();

  segment_reorder_cumulative_ack_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Descriptor words waiting for the driver, and result words still owed by the block.
  in_word_t  seg_backlog [$];
  out_word_t results_due [$];

  // Shadow of the receiver: cumulative ack point and the table of early segments.
  logic [31:0] ack_upto;
  logic        held_live  [HOLD_SLOTS];
  logic [31:0] held_start [HOLD_SLOTS];
  logic [15:0] held_len   [HOLD_SLOTS];
  logic [7:0]  held_tag   [HOLD_SLOTS];

  // Handshake flags of the last rising edge, read by the falling-edge driver.
  bit        in_fire;
  bit        out_fire;
  int        quiet_cycles;
  int        mismatches;
  int        segments_sent;
  bit        src_idle;
  bit        snk_idle;
  int        src_wait;
  int        snk_wait;
  out_word_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_cycles(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_data(logic [31:0] start, logic [15:0] len, logic [7:0] tag);
    in_word_t w;
    w.action     = ACT_DATA;
    w.seg_start  = start;
    w.seg_bytes  = len;
    w.buffer_tag = tag;
    return w;
  endfunction

  // Works out the result words of one accepted descriptor and updates the shadow state.
  // A segment above the point goes to the lowest free entry unless its start is already
  // held or the table is full. A segment at the point is delivered, then held entries that
  // continue the point are drained one by one, and entries the point has passed are freed.
  task automatic absorb_segment(input in_word_t w);
    out_word_t burst [$];
    out_word_t r;
    int        free_ix;
    bit        dup;
    bit        chained;
    if (w.action == ACT_FIN) begin
      r = '0;
      r.kind = KIND_FINACK;
      burst.push_back(r);
    end else begin
      if (w.seg_start > ack_upto) begin
        free_ix = -1;
        dup = 1'b0;
        for (int i = 0; i < HOLD_SLOTS; i++) begin
          if (held_live[i]) begin
            if (held_start[i] == w.seg_start) dup = 1'b1;
          end else if (free_ix < 0) begin
            free_ix = i;
          end
        end
        if (!dup && free_ix >= 0) begin
          held_live[free_ix]  = 1'b1;
          held_start[free_ix] = w.seg_start;
          held_len[free_ix]   = w.seg_bytes;
          held_tag[free_ix]   = w.buffer_tag;
        end
      end else if (w.seg_start == ack_upto) begin
        r = '0;
        r.kind      = KIND_DELIVER;
        r.out_start = w.seg_start;
        r.out_bytes = w.seg_bytes;
        r.out_tag   = w.buffer_tag;
        burst.push_back(r);
        ack_upto = ack_upto + 32'(w.seg_bytes);
        chained = 1'b1;
        while (chained) begin
          chained = 1'b0;
          for (int i = 0; i < HOLD_SLOTS; i++) begin
            if (held_live[i] && held_start[i] == ack_upto) begin
              r = '0;
              r.kind      = KIND_DELIVER;
              r.out_start = held_start[i];
              r.out_bytes = held_len[i];
              r.out_tag   = held_tag[i];
              burst.push_back(r);
              held_live[i] = 1'b0;
              ack_upto = ack_upto + 32'(held_len[i]);
              chained = 1'b1;
              break;
            end
          end
        end
        for (int i = 0; i < HOLD_SLOTS; i++) begin
          if (held_live[i] && held_start[i] < ack_upto) held_live[i] = 1'b0;
        end
      end
      r = '0;
      r.kind = KIND_ACK;
      burst.push_back(r);
    end
    // Every word of the burst carries the final point; only the closing one has last set.
    foreach (burst[k]) begin
      burst[k].ack_point = ack_upto;
      burst[k].last      = (k == burst.size() - 1);
      results_due.push_back(burst[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Both handshakes are seen at the rising edge. Accepted descriptors feed the shadow
  // model right away, so the expected words are queued before any of them can appear.
  always @(posedge clk) begin
    in_fire  = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    if (in_fire) absorb_segment(in_if.data);
    if (out_fire) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word expected none, actual %p", $time, out_if.data);
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_if.data.kind));
        check_field("out_start", want.out_start, out_if.data.out_start);
        check_field("out_bytes", 32'(want.out_bytes), 32'(out_if.data.out_bytes));
        check_field("out_tag", 32'(want.out_tag), 32'(out_if.data.out_tag));
        check_field("ack_point", want.ack_point, out_if.data.ack_point);
        check_field("last", 32'(want.last), 32'(out_if.data.last));
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Inputs change at the falling edge. A new descriptor is presented only when the
  // previous one was taken (or none was up), and a random gap may come in between.
  // The receiver side drops ready for random stretches independent of valid, so
  // stalls land anywhere inside a drain burst.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_fire) begin
        if (src_wait > 0) begin
          in_if.valid <= 1'b0;
          src_wait--;
        end else if (seg_backlog.size() != 0) begin
          in_if.data  <= seg_backlog.pop_front();
          in_if.valid <= 1'b1;
          src_wait = gap_cycles(src_idle);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (snk_wait > 0) begin
        out_if.ready <= 1'b0;
        snk_wait--;
      end else begin
        out_if.ready <= 1'b1;
        snk_wait = gap_cycles(snk_idle);
      end
    end
  end

  // Waits at rising edges until every queued word was taken and every result arrived.
  task automatic settle();
    @(posedge clk);
    while (seg_backlog.size() != 0 || in_if.valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic pick_idling();
    if ($urandom_range(0, 3) == 0) begin
      src_idle = 1'b0;
      snk_idle = 1'b0;
    end else begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
    end
  endtask

  // One window of the stream just past the current point: a run of contiguous segments
  // sent in shuffled order, so most of them are held and then drained by the one that
  // lands on the point. Now and then a segment goes missing, which leaves the rest
  // parked, and noise is mixed in: finish words, resent segments, starts below the
  // point, starts inside the window and starts anywhere.
  task automatic queue_window();
    logic [31:0] lo;
    logic [31:0] run;
    logic [31:0] starts [$];
    logic [15:0] lens [$];
    int          perm [$];
    int          n;
    int          j;
    int          k;
    int          tmp;
    int          r;
    in_word_t    w;
    lo  = ack_upto;
    run = ack_upto;
    n   = $urandom_range(1, 8);
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 5) lens.push_back(16'd0);
      else if (r < 10) lens.push_back(16'hFFFF);
      else if (r < 20) lens.push_back(16'(TABLE_STRIDE));
      else lens.push_back(16'($urandom_range(1, 2000)));
      starts.push_back(run);
      run = run + 32'(lens[j]);
      perm.push_back(j);
    end
    for (j = n - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = perm[j];
      perm[j] = perm[k];
      perm[k] = tmp;
    end
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) >= 8) begin
        seg_backlog.push_back(make_data(starts[perm[j]], lens[perm[j]],
                                        8'($urandom_range(0, 255))));
        segments_sent++;
      end
      r = $urandom_range(0, 99);
      w = make_data($urandom(), 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      if (r < 6) begin
        w.action = ACT_FIN;
        seg_backlog.push_back(w);
      end else if (r < 12) begin
        w.seg_start = starts[perm[j]];
        seg_backlog.push_back(w);
      end else if (r < 17) begin
        w.seg_start = lo - 32'($urandom_range(1, 5000));
        seg_backlog.push_back(w);
      end else if (r < 22) begin
        w.seg_start = lo + 32'($urandom_range(0, run - lo));
        seg_backlog.push_back(w);
      end else if (r < 24) begin
        seg_backlog.push_back(w);
      end
    end
  endtask

  initial begin
    logic [31:0]    run;
    in_word_t       w;
    rst_n        = 1'b0;
    ack_upto     = '0;
    for (int i = 0; i < HOLD_SLOTS; i++) held_live[i] = 1'b0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: finish on an empty stream, a zero-length word at the point,
    // a full-width tag, a word below the point, a held word and a second
    // one with the same start, a held word the drain will pass over, then the word
    // at the point that drains two entries and frees the passed one.
    w = make_data('0, '0, '0);
    w.action = ACT_FIN;
    seg_backlog.push_back(w);
    seg_backlog.push_back(make_data(32'd0, 16'd0, 8'd0));
    seg_backlog.push_back(make_data(32'd0, 16'd100, 8'hFF));
    seg_backlog.push_back(make_data(32'd50, 16'd10, 8'h11));
    seg_backlog.push_back(make_data(32'd300, 16'd100, 8'd1));
    seg_backlog.push_back(make_data(32'd300, 16'd7, 8'd2));
    seg_backlog.push_back(make_data(32'd200, 16'd100, 8'd3));
    seg_backlog.push_back(make_data(32'd250, 16'd10, 8'd4));
    seg_backlog.push_back(make_data(32'd100, 16'd100, 8'd5));
    settle();

    // Fill every table entry with contiguous segments, offer one more that must be
    // dropped, then send the word at the point: the longest burst the block can give.
    run = ack_upto;
    for (int i = 0; i <= HOLD_SLOTS; i++)
      seg_backlog.push_back(make_data(run + 32'(TABLE_STRIDE * (i + 1)),
                                      16'(TABLE_STRIDE), 8'(i)));
    seg_backlog.push_back(make_data(run, 16'(TABLE_STRIDE), 8'hA5));
    seg_backlog.push_back(make_data(32'hFFFF_FFFF, 16'hFFFF, 8'h5A));
    w = make_data(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    w.action = ACT_FIN;
    seg_backlog.push_back(w);
    settle();

    while (segments_sent < RANDOM_SEGMENTS) begin
      pick_idling();
      queue_window();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
